/* rtl/core/lre_pkg.sv */
// Shared types, codes and helper functions of the load/register execute unit.
package lre_pkg;

	localparam int unsigned AddrBitsDef  = 16;
	localparam int unsigned CycleBitsDef = 32;
	localparam int unsigned CycleOutW    = 32;
	localparam int unsigned PcW          = 16;
	localparam int unsigned ApbAddrW     = 3;
	localparam int unsigned ApbDataW     = 32;
	localparam int unsigned InDataW      = 32;
	localparam int unsigned OutDataW     = 96;

	localparam logic       OP_WRITE     = 1'b0;
	localparam logic       OP_EXEC      = 1'b1;
	localparam logic       REG_START_PC = 1'b0;

	localparam logic [1:0] TGT_A = 2'd0;
	localparam logic [1:0] TGT_X = 2'd1;
	localparam logic [1:0] TGT_Y = 2'd2;

	localparam logic [3:0] MODE_IMM   = 4'd0;
	localparam logic [3:0] MODE_ZPG   = 4'd1;
	localparam logic [3:0] MODE_ZPG_X = 4'd2;
	localparam logic [3:0] MODE_ZPG_Y = 4'd3;
	localparam logic [3:0] MODE_ABS   = 4'd4;
	localparam logic [3:0] MODE_ABS_X = 4'd5;
	localparam logic [3:0] MODE_ABS_Y = 4'd6;
	localparam logic [3:0] MODE_IND_X = 4'd7;
	localparam logic [3:0] MODE_IND_Y = 4'd8;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_OP2,
		ST_ADDR,
		ST_PTR_HI,
		ST_PTR_EA,
		ST_DATA
	} lre_state_t;

	function automatic logic lre_legal(input logic [1:0] tgt, input logic [3:0] mode);
		logic ok;
		ok = 1'b0;
		case (tgt)
			TGT_A: ok = (mode inside {MODE_IMM, MODE_ZPG, MODE_ZPG_X, MODE_ABS, MODE_ABS_X,
				MODE_ABS_Y, MODE_IND_X, MODE_IND_Y});
			TGT_X: ok = (mode inside {MODE_IMM, MODE_ZPG, MODE_ZPG_Y, MODE_ABS, MODE_ABS_Y});
			TGT_Y: ok = (mode inside {MODE_IMM, MODE_ZPG, MODE_ZPG_X, MODE_ABS, MODE_ABS_X});
			default: ok = 1'b0;
		endcase
		return ok;
	endfunction

	function automatic logic [2:0] lre_cycles(input logic [3:0] mode, input logic crossed);
		logic [2:0] c;
		c = 3'd0;
		case (mode)
			MODE_IMM:   c = 3'd2;
			MODE_ZPG:   c = 3'd3;
			MODE_ZPG_X, MODE_ZPG_Y, MODE_ABS: c = 3'd4;
			MODE_ABS_X, MODE_ABS_Y: c = 3'd4 + {2'd0, crossed};
			MODE_IND_X: c = 3'd6;
			MODE_IND_Y: c = 3'd5 + {2'd0, crossed};
			default:    c = 3'd0;
		endcase
		return c;
	endfunction

endpackage

/* rtl/core/load_register_execute_unit.sv */
// Top level of the load/register execute unit: item engine, byte memory and APB start_pc register.
//
// Input stream (s_*): one item per transfer. tuser = operation (0 store a byte,
// 1 execute LDA/LDX/LDY). Output stream (m_*): one result per input item, in order,
// carrying A, X, Y, PC, cycle count, Z, N, effective address, page cross and the
// illegal-pair flag.
// An input register takes the next item while the engine works on the current one,
// and an output register holds a finished result until the receiver takes it.
// Store items and illegal pairs complete in ST_IDLE. Loads step through operand
// fetch at PC+1 and PC+2, address and data read (ST_IDLE, ST_OP2, ST_ADDR, ST_DATA);
// (indirect,X) and (indirect),Y add ST_PTR_HI and ST_PTR_EA, since both pointer
// bytes come through the same single-port memory before the data read.
// When the receiver stalls, the engine finishes its item and waits with it; the
// input register then fills and s_tready drops.
// Reset clears A, X, Y, flags, cycle count and PC (start_pc resets to 0); memory
// contents are undefined until stored. An APB write to start_pc also loads PC.
module load_register_execute_unit #(
	parameter int unsigned ADDR_BITS  = lre_pkg::AddrBitsDef,
	parameter int unsigned CYCLE_BITS = lre_pkg::CycleBitsDef
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// target[1:0], mode[5:2], mem_address[21:6], mem_data[29:22], zero pad
	input  logic [lre_pkg::InDataW-1:0]  s_tdata,
	// operation[0]
	input  logic                         s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// acc_value[7:0], index_x_value[15:8], index_y_value[23:16], program_counter[39:24],
	// cycle_total[71:40], zero_flag[72], negative_flag[73], effective_address[89:74],
	// page_crossed[90], illegal_combination[91], zero pad
	output logic [lre_pkg::OutDataW-1:0] m_tdata,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lre_pkg::ApbAddrW-1:0] paddr,
	input  logic [lre_pkg::ApbDataW-1:0] pwdata,
	output logic [lre_pkg::ApbDataW-1:0] prdata,
	output logic                         pready
);
	import lre_pkg::*;

	localparam int unsigned MemDepth = 2 ** ADDR_BITS;

	lre_state_t state_q, state_nxt;

	logic                  in_valid_q;
	logic                  in_op_q;
	logic [1:0]            in_tgt_q;
	logic [3:0]            in_mode_q;
	logic [ADDR_BITS-1:0]  in_addr_q;
	logic [7:0]            in_data_q;

	logic [1:0]            tgt_q;
	logic [3:0]            mode_q;
	logic [7:0]            acc_q, x_q, y_q;
	logic [ADDR_BITS-1:0]  pc_q;
	logic [PcW-1:0]        start_pc_q;
	logic [CYCLE_BITS-1:0] cyc_q;
	logic                  z_q, n_q;
	logic [7:0]            op1_q, ptr_q, lo_q;
	logic [ADDR_BITS-1:0]  ea_q;
	logic                  crossed_q;

	logic [7:0]            mem [MemDepth];
	logic [7:0]            rdata_q;
	logic                  mem_en, mem_we;
	logic [ADDR_BITS-1:0]  mem_addr;

	logic                  m_valid_q;
	logic [OutDataW-1:0]   m_data_q;

	logic                  out_free, start, done, legal, cfg_wr;
	logic [ADDR_BITS-1:0]  base_addr, ind_base, calc_ea;
	logic [7:0]            zp_sum, ptr_calc, ptr_next;
	logic                  calc_cross;
	logic [7:0]            ld_val;
	logic [7:0]            acc_new, x_new, y_new;
	logic [ADDR_BITS-1:0]  pc_new, res_ea;
	logic [CYCLE_BITS-1:0] cyc_new;
	logic                  z_new, n_new, res_cross, res_illegal;

	assign out_free = !m_valid_q || m_tready;
	assign legal    = lre_legal(in_tgt_q, in_mode_q);
	assign s_tready = !in_valid_q || start;
	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign pready   = 1'b1;
	assign cfg_wr   = psel && penable && pwrite && (paddr[2] == REG_START_PC);
	assign prdata   = (paddr[2] == REG_START_PC) ? ApbDataW'(start_pc_q) : '0;

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid_q && in_op_q == OP_EXEC && legal) begin
					state_nxt = ST_OP2;
				end
			end
			ST_OP2:  state_nxt = ST_ADDR;
			ST_ADDR: begin
				if (mode_q == MODE_IND_X || mode_q == MODE_IND_Y) begin
					state_nxt = ST_PTR_HI;
				end else begin
					state_nxt = ST_DATA;
				end
			end
			ST_PTR_HI: state_nxt = ST_PTR_EA;
			ST_PTR_EA: state_nxt = ST_DATA;
			ST_DATA: begin
				if (out_free) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		base_addr  = ADDR_BITS'({rdata_q, op1_q});
		ind_base   = ADDR_BITS'({rdata_q, lo_q});
		zp_sum     = op1_q + ((mode_q == MODE_ZPG_Y) ? y_q : x_q);
		ptr_calc   = (mode_q == MODE_IND_X) ? op1_q + x_q : op1_q;
		ptr_next   = ptr_q + 8'd1;
		calc_ea    = '0;
		calc_cross = 1'b0;
		case (mode_q)
			MODE_IMM:   calc_ea = pc_q + ADDR_BITS'(1);
			MODE_ZPG:   calc_ea = ADDR_BITS'(op1_q);
			MODE_ZPG_X, MODE_ZPG_Y: calc_ea = ADDR_BITS'(zp_sum);
			MODE_ABS:   calc_ea = base_addr;
			MODE_ABS_X: calc_ea = base_addr + ADDR_BITS'(x_q);
			MODE_ABS_Y: calc_ea = base_addr + ADDR_BITS'(y_q);
			default:    calc_ea = base_addr;
		endcase
		if (state_q == ST_PTR_EA) begin
			calc_ea = (mode_q == MODE_IND_Y) ? ind_base + ADDR_BITS'(y_q) : ind_base;
			calc_cross = (mode_q == MODE_IND_Y) &&
				(calc_ea[ADDR_BITS-1:8] != ind_base[ADDR_BITS-1:8]);
		end else if (mode_q == MODE_ABS_X || mode_q == MODE_ABS_Y) begin
			calc_cross = calc_ea[ADDR_BITS-1:8] != base_addr[ADDR_BITS-1:8];
		end
	end

	always_comb begin
		mem_en      = 1'b0;
		mem_we      = 1'b0;
		mem_addr    = '0;
		start       = 1'b0;
		done        = 1'b0;
		ld_val      = rdata_q;
		acc_new     = acc_q;
		x_new       = x_q;
		y_new       = y_q;
		pc_new      = pc_q;
		cyc_new     = cyc_q;
		z_new       = z_q;
		n_new       = n_q;
		res_ea      = '0;
		res_cross   = 1'b0;
		res_illegal = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid_q) begin
					if (in_op_q == OP_EXEC && legal) begin
						start    = 1'b1;
						mem_en   = 1'b1;
						mem_addr = pc_q + ADDR_BITS'(1);
					end else if (out_free) begin
						start       = 1'b1;
						done        = 1'b1;
						res_illegal = (in_op_q == OP_EXEC);
						if (in_op_q == OP_WRITE) begin
							mem_en   = 1'b1;
							mem_we   = 1'b1;
							mem_addr = in_addr_q;
						end
					end
				end
			end
			ST_OP2: begin
				mem_en   = 1'b1;
				mem_addr = pc_q + ADDR_BITS'(2);
			end
			ST_ADDR: begin
				mem_en   = 1'b1;
				mem_addr = (mode_q == MODE_IND_X || mode_q == MODE_IND_Y) ?
					ADDR_BITS'(ptr_calc) : calc_ea;
			end
			ST_PTR_HI: begin
				mem_en   = 1'b1;
				mem_addr = ADDR_BITS'(ptr_next);
			end
			ST_PTR_EA: begin
				mem_en   = 1'b1;
				mem_addr = calc_ea;
			end
			ST_DATA: begin
				if (out_free) begin
					done      = 1'b1;
					res_ea    = ea_q;
					res_cross = crossed_q;
					case (tgt_q)
						TGT_A:   acc_new = ld_val;
						TGT_X:   x_new   = ld_val;
						default: y_new   = ld_val;
					endcase
					z_new   = (ld_val == 8'd0);
					n_new   = ld_val[7];
					pc_new  = pc_q + ((mode_q inside {MODE_ABS, MODE_ABS_X, MODE_ABS_Y}) ?
						ADDR_BITS'(3) : ADDR_BITS'(2));
					cyc_new = cyc_q + CYCLE_BITS'(lre_cycles(mode_q, crossed_q));
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_en) begin
			if (mem_we) begin
				mem[mem_addr] <= in_data_q;
			end else begin
				rdata_q <= mem[mem_addr];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_valid_q <= 1'b0;
			m_valid_q  <= 1'b0;
			acc_q      <= '0;
			x_q        <= '0;
			y_q        <= '0;
			pc_q       <= '0;
			start_pc_q <= '0;
			cyc_q      <= '0;
			z_q        <= 1'b0;
			n_q        <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (s_tvalid && s_tready) begin
				in_valid_q <= 1'b1;
			end else if (start) begin
				in_valid_q <= 1'b0;
			end
			if (done) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			acc_q <= acc_new;
			x_q   <= x_new;
			y_q   <= y_new;
			cyc_q <= cyc_new;
			z_q   <= z_new;
			n_q   <= n_new;
			if (cfg_wr) begin
				start_pc_q <= pwdata[PcW-1:0];
				pc_q       <= ADDR_BITS'(pwdata[PcW-1:0]);
			end else begin
				pc_q <= pc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			in_op_q   <= s_tuser;
			in_tgt_q  <= s_tdata[1:0];
			in_mode_q <= s_tdata[5:2];
			in_addr_q <= ADDR_BITS'(s_tdata[21:6]);
			in_data_q <= s_tdata[29:22];
		end
		if (start) begin
			tgt_q  <= in_tgt_q;
			mode_q <= in_mode_q;
		end
		if (state_q == ST_OP2) begin
			op1_q <= rdata_q;
		end
		if (state_q == ST_ADDR) begin
			ptr_q     <= ptr_calc;
			ea_q      <= calc_ea;
			crossed_q <= calc_cross;
		end
		if (state_q == ST_PTR_HI) begin
			lo_q <= rdata_q;
		end
		if (state_q == ST_PTR_EA) begin
			ea_q      <= calc_ea;
			crossed_q <= calc_cross;
		end
		if (done) begin
			m_data_q <= {4'd0, res_illegal, res_cross, PcW'(res_ea), n_new, z_new,
				CycleOutW'(cyc_new), PcW'(pc_new), y_new, x_new, acc_new};
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		mem_en && mem_we |-> state_q == ST_IDLE)
		else $error("memory store outside idle");

	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> out_free)
		else $error("result overwrites pending transfer");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_valid_q && m_data_q[91] |-> m_data_q[89:74] == '0 && !m_data_q[90])
		else $error("illegal pair carries an address");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_PTR_EA |-> $past(state_q) == ST_PTR_HI)
		else $error("pointer sequence broken");

endmodule
